[sv/uule_pkg.sv]
// Package for the uuencode line encoder: payload words, queue entry, sequencer states.
// Holds character constants and the 6-bit-to-character mapping. No dependencies.
package uule_pkg;

  localparam int CNT_W      = 6;
  localparam int SUM_W      = 14;
  localparam int NUM_DIGITS = 5;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_BACKQ  = 8'h60;
  localparam logic [7:0] CHAR_OFFSET = 8'h20;
  localparam logic [7:0] LEN_OFFSET  = 8'd32;

  // floor(s / 10) == (s * RECIP10) >> RECIP_SHIFT for every 16-bit s
  localparam logic [15:0] RECIP10     = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       run_last;
    logic       line_end;
  } out_item_t;

  // Work for the back end, one entry per input word that yields characters
  typedef struct packed {
    logic             has_len;
    logic [7:0]       len_char;
    logic             has_grp;
    logic [23:0]      grp;
    logic             is_end;
    logic [SUM_W-1:0] sum;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LEN,
    B_G0,
    B_G1,
    B_G2,
    B_G3,
    B_CR1,
    B_LF1,
    B_DIG,
    B_CR2,
    B_LF2
  } back_state_t;

  function automatic logic [7:0] six_to_char(input logic [5:0] v);
    six_to_char = (v == 6'd0) ? CHAR_BACKQ : ({2'b00, v} + CHAR_OFFSET);
  endfunction

endpackage

[sv/uu_line_encoder_top.sv]
// Top level of the uuencode line encoder with decimal checksum trailer.
// Instantiates uule_front, uule_queue and uule_back; depends on uule_pkg.
//
//  channel | ports                          | word
//  --------+--------------------------------+-----------------------------------
//  input   | in_valid, in_ready, in_data    | in_item_t: data_byte, byte_count
//  output  | out_valid, out_ready, out_data | out_item_t: char_out, run_last,
//          |                                |   line_end
//
// Flow: the front takes one input word per cycle while the two-entry job
// queue has room. The back sends one character per cycle through its output
// register while out_ready is high: a length character, four per encoded
// group, and CR LF, the checksum digits and CR LF as the trailer. The digit
// phase waits for the divide-by-ten unit to finish, which starts when the job
// is loaded. Mid-line, three bytes yield four characters of the output.
// Reset: rst_n clears line state, queue pointers and the sequencer; no sweep.
// Stalls: out_ready low holds the output register; the queue absorbs two
// jobs, then in_ready drops until the back frees an entry.
module uu_line_encoder_top import uule_pkg::*; #(
  parameter int MAX_LINE_BYTES = 45
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic q_full, q_push, q_pop, head_valid;
  job_t q_job, head_job;

  // classify each byte and fold it into the line state
  uule_front #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // decouple byte intake from character output
  uule_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // expand jobs into characters
  uule_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[sv/uule_front.sv]
// Front end: accepts data words, tracks line state and builds back-end jobs.
// Depends on uule_pkg.
module uule_front import uule_pkg::*; #(
  parameter int MAX_LINE_BYTES = 45
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_LINE_BYTES);

  logic             in_line_r, in_line_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [15:0]      grp_r, grp_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic             take;
  logic             first;
  logic [CNT_W-1:0] cnt, left0, left1;
  logic [15:0]      grp0, grp1;
  logic [1:0]       fill0, fill1;
  logic [SUM_W-1:0] sum0, sum1;
  logic             full_grp, line_done;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign first    = !in_line_r;

  always_comb begin
    cnt = in_data.byte_count;
    if (cnt == '0) begin
      cnt = CNT_W'(1);
    end
    if (cnt > MaxCnt) begin
      cnt = MaxCnt;
    end
    left0 = first ? cnt : left_r;
    grp0  = first ? 16'h0 : grp_r;
    fill0 = first ? 2'd0 : fill_r;
    sum0  = first ? '0 : sum_r;

    sum1      = sum0 + {{(SUM_W-8){1'b0}}, in_data.data_byte};
    left1     = left0 - CNT_W'(1);
    full_grp  = (fill0 == 2'd2);
    line_done = (left1 == '0);

    q_job          = '0;
    q_job.has_len  = first;
    q_job.len_char = {2'b00, cnt} + LEN_OFFSET;
    q_job.is_end   = line_done;
    q_job.sum      = sum1;

    if (full_grp) begin
      grp1  = 16'h0;
      fill1 = 2'd0;
      q_job.has_grp = 1'b1;
      q_job.grp     = {grp0, in_data.data_byte};
    end else begin
      grp1  = {grp0[7:0], in_data.data_byte};
      fill1 = fill0 + 2'd1;
    end

    // pad a short group with zero bytes at line end
    if (line_done && fill1 == 2'd1) begin
      q_job.has_grp = 1'b1;
      q_job.grp     = {grp1[7:0], 16'h0};
    end else if (line_done && fill1 == 2'd2) begin
      q_job.has_grp = 1'b1;
      q_job.grp     = {grp1, 8'h0};
    end

    q_push = take && (q_job.has_len || q_job.has_grp || q_job.is_end);

    in_line_nxt = in_line_r;
    left_nxt    = left_r;
    grp_nxt     = grp_r;
    fill_nxt    = fill_r;
    sum_nxt     = sum_r;
    if (take) begin
      in_line_nxt = !line_done;
      left_nxt    = left1;
      grp_nxt     = line_done ? 16'h0 : grp1;
      fill_nxt    = line_done ? 2'd0 : fill1;
      sum_nxt     = sum1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_line_r <= 1'b0;
      left_r    <= '0;
      grp_r     <= 16'h0;
      fill_r    <= 2'd0;
      sum_r     <= '0;
    end else begin
      in_line_r <= in_line_nxt;
      left_r    <= left_nxt;
      grp_r     <= grp_nxt;
      fill_r    <= fill_nxt;
      sum_r     <= sum_nxt;
    end
  end

endmodule

[sv/uule_queue.sv]
// Two-entry job queue between front and back end.
// Depends on uule_pkg.
module uule_queue import uule_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = ent_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job popped from empty queue");

endmodule

[sv/uule_back.sv]
// Back end: walks each job through its characters into the output register.
// Converts the line sum to decimal digits, one divide-by-ten a cycle. Depends on uule_pkg.
module uule_back import uule_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  back_state_t state_r, state_nxt, after;
  job_t        job_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [SUM_W-1:0] conv_s_r;
  logic [2:0]       conv_cnt_r;
  logic [3:0]       dig_r [NUM_DIGITS];
  logic [2:0]       dig_idx_r;

  logic        conv_done, out_free, emit, done, load;
  logic [29:0] prod;
  logic [SUM_W-1:0] quot, quot10;
  logic [3:0]  rem;
  logic [7:0]  char_sel;

  function automatic back_state_t first_state(input job_t j);
    if (j.has_len) begin
      first_state = B_LEN;
    end else if (j.has_grp) begin
      first_state = B_G0;
    end else begin
      first_state = B_CR1;
    end
  endfunction

  function automatic logic [2:0] top_digit(input logic [SUM_W-1:0] s);
    if (s >= SUM_W'(10000)) begin
      top_digit = 3'd4;
    end else if (s >= SUM_W'(1000)) begin
      top_digit = 3'd3;
    end else if (s >= SUM_W'(100)) begin
      top_digit = 3'd2;
    end else if (s >= SUM_W'(10)) begin
      top_digit = 3'd1;
    end else begin
      top_digit = 3'd0;
    end
  endfunction

  assign conv_done = (conv_cnt_r == 3'(NUM_DIGITS));
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = (state_r != B_IDLE) && out_free && !(state_r == B_DIG && !conv_done);

  // next state
  always_comb begin
    after = B_IDLE;
    done  = 1'b0;
    case (state_r)
      B_LEN: begin
        if (job_r.has_grp) begin
          after = B_G0;
        end else if (job_r.is_end) begin
          after = B_CR1;
        end else begin
          done = 1'b1;
        end
      end
      B_G0: after = B_G1;
      B_G1: after = B_G2;
      B_G2: after = B_G3;
      B_G3: begin
        if (job_r.is_end) begin
          after = B_CR1;
        end else begin
          done = 1'b1;
        end
      end
      B_CR1: after = B_LF1;
      B_LF1: after = B_DIG;
      B_DIG: after = (dig_idx_r == 3'd0) ? B_CR2 : B_DIG;
      B_CR2: after = B_LF2;
      B_LF2: done = 1'b1;
      default: after = B_IDLE;
    endcase

    load = head_valid && (state_r == B_IDLE || (emit && done));
    if (load) begin
      state_nxt = first_state(head_job);
    end else if (emit) begin
      state_nxt = done ? B_IDLE : after;
    end else begin
      state_nxt = state_r;
    end
  end

  // character for the current state
  always_comb begin
    case (state_r)
      B_LEN:   char_sel = job_r.len_char;
      B_G0:    char_sel = six_to_char(job_r.grp[23:18]);
      B_G1:    char_sel = six_to_char(job_r.grp[17:12]);
      B_G2:    char_sel = six_to_char(job_r.grp[11:6]);
      B_G3:    char_sel = six_to_char(job_r.grp[5:0]);
      B_CR1:   char_sel = CHAR_CR;
      B_LF1:   char_sel = CHAR_LF;
      B_DIG:   char_sel = CHAR_ZERO + {4'h0, dig_r[dig_idx_r]};
      B_CR2:   char_sel = CHAR_CR;
      B_LF2:   char_sel = CHAR_LF;
      default: char_sel = 8'h00;
    endcase
  end

  assign pop = load;

  // one divide-by-ten step
  assign prod   = {16'h0, conv_s_r} * {14'h0, RECIP10};
  assign quot   = {{(SUM_W-(30-RECIP_SHIFT)){1'b0}}, prod[29:RECIP_SHIFT]};
  assign quot10 = {quot[SUM_W-4:0], 3'b000} + {quot[SUM_W-2:0], 1'b0};
  assign rem    = 4'(conv_s_r - quot10);

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= head_job;
    end
    if (emit) begin
      out_data_r.char_out <= char_sel;
      out_data_r.run_last <= done;
      out_data_r.line_end <= (state_r == B_LF2);
    end
    if (load) begin
      conv_s_r <= head_job.sum;
    end else if (!conv_done) begin
      conv_s_r <= quot;
    end
    if (!load && !conv_done) begin
      dig_r[conv_cnt_r] <= rem;
    end
    if (load) begin
      dig_idx_r <= top_digit(head_job.sum);
    end else if (emit && state_r == B_DIG && dig_idx_r != 3'd0) begin
      dig_idx_r <= dig_idx_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      conv_cnt_r  <= 3'(NUM_DIGITS);
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        conv_cnt_r <= 3'd0;
      end else if (!conv_done) begin
        conv_cnt_r <= conv_cnt_r + 3'd1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_end_has_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.line_end |-> out_data_r.run_last)
    else $error("line end without last-of-word mark");

  a_dig_end_job: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIG |-> job_r.is_end)
    else $error("digit phase outside a line-ending job");

  a_dig_ready: assert property (@(posedge clk) disable iff (!rst_n)
    emit && state_r == B_DIG |-> conv_done && dig_idx_r <= 3'(NUM_DIGITS - 1))
    else $error("digit sent before conversion finished");

endmodule
